// ===== rtl/rha_pkg.sv =====
package rha_pkg;

  localparam int ITERATIONS_DEF = 16;
  localparam int ANGLE_BITS_DEF = 16;

  // Working width of the x and y datapath. After the half-plane fold the
  // magnitude grows by at most the CORDIC gain times root two, so nineteen
  // signed bits never overflow.
  localparam int XY_W = 19;

  localparam int TAB_LEN = 24;

  // round(atan(2^-i) * 2^31 / pi)
  localparam logic [31:0] ATAN_Q31 [TAB_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Side information that travels alongside each beat down the chain.
  typedef struct packed {
    logic        valid;
    logic        zero;
    logic [15:0] heading;
  } side_t;

  // Arctangent of 2^-step rounded to a binary angle of abits bits.
  function automatic logic [31:0] atan_entry(input int step, input int abits);
    logic [32:0] sum;
    sum = '0;
    if (step >= TAB_LEN) begin
      return 32'd0;
    end
    sum = {1'b0, ATAN_Q31[5'(step)]} + (33'd1 << (31 - abits));
    return 32'(sum >> (32 - abits));
  endfunction

endpackage

// ===== rtl/rha_prerot.sv =====
module rha_prerot import rha_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  logic signed [15:0]           vec_x,
  input  logic signed [15:0]           vec_y,
  input  logic        [15:0]           heading,
  output logic signed [XY_W-1:0]       x_o,
  output logic signed [XY_W-1:0]       y_o,
  output logic        [ANGLE_BITS-1:0] z_o,
  output side_t                        side_o
);

  logic signed [XY_W-1:0] x_ext;
  logic signed [XY_W-1:0] y_ext;
  logic                   neg;
  logic signed [XY_W-1:0] x_r, x_nxt;
  logic signed [XY_W-1:0] y_r, y_nxt;
  logic [ANGLE_BITS-1:0]  z_r, z_nxt;
  side_t                  side_r, side_nxt;

  assign x_ext = XY_W'(vec_x);
  assign y_ext = XY_W'(vec_y);
  assign neg   = vec_x[15];

  // A vector in the left half-plane is turned through half a circle so that
  // the micro-rotations only ever have to cover a quarter turn either way.
  always_comb begin
    x_nxt            = neg ? -x_ext : x_ext;
    y_nxt            = neg ? -y_ext : y_ext;
    z_nxt            = neg ? {1'b1, {(ANGLE_BITS-1){1'b0}}} : '0;
    side_nxt.valid   = load;
    side_nxt.zero    = (vec_x == 16'sd0) && (vec_y == 16'sd0);
    side_nxt.heading = heading;
  end

  always_ff @(posedge clk) begin
    x_r            <= x_nxt;
    y_r            <= y_nxt;
    z_r            <= z_nxt;
    side_r.zero    <= side_nxt.zero;
    side_r.heading <= side_nxt.heading;
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else begin
      side_r.valid <= side_nxt.valid;
    end
  end

  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign side_o = side_r;

endmodule

// ===== rtl/rha_cell.sv =====
module rha_cell import rha_pkg::*; #(
  parameter int STEP       = 0,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [XY_W-1:0]       x_i,
  input  logic signed [XY_W-1:0]       y_i,
  input  logic        [ANGLE_BITS-1:0] z_i,
  input  side_t                        side_i,
  output logic signed [XY_W-1:0]       x_o,
  output logic signed [XY_W-1:0]       y_o,
  output logic        [ANGLE_BITS-1:0] z_o,
  output side_t                        side_o
);

  localparam logic [ANGLE_BITS-1:0] ENTRY = ANGLE_BITS'(atan_entry(STEP, ANGLE_BITS));

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [XY_W-1:0] x_r, x_nxt;
  logic signed [XY_W-1:0] y_r, y_nxt;
  logic [ANGLE_BITS-1:0]  z_r, z_nxt;
  side_t                  side_r;

  assign xs = x_i >>> STEP;
  assign ys = y_i >>> STEP;

  // Rotate towards the x axis: the sign of y picks the direction.
  always_comb begin
    if (!y_i[XY_W-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ENTRY;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ENTRY;
    end
  end

  always_ff @(posedge clk) begin
    x_r            <= x_nxt;
    y_r            <= y_nxt;
    z_r            <= z_nxt;
    side_r.zero    <= side_i.zero;
    side_r.heading <= side_i.heading;
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else begin
      side_r.valid <= side_i.valid;
    end
  end

  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign side_o = side_r;

endmodule

// ===== rtl/rha_post.sv =====
module rha_post import rha_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic        [ANGLE_BITS-1:0] z_i,
  input  side_t                        side_i,
  output logic                         valid_o,
  output logic signed [15:0]           rel_angle_o,
  output logic                         zero_o
);

  logic [15:0] a16;
  logic [15:0] rel_r, rel_nxt;
  logic        zero_r;
  logic        valid_r;

  generate
    if (ANGLE_BITS >= 16) begin : g_trunc
      assign a16 = z_i[ANGLE_BITS-1 -: 16];
    end else begin : g_widen
      assign a16 = {z_i, {(16-ANGLE_BITS){1'b0}}};
    end
  endgenerate

  assign rel_nxt = side_i.zero ? 16'd0 : (a16 - side_i.heading);

  always_ff @(posedge clk) begin
    rel_r  <= rel_nxt;
    zero_r <= side_i.zero;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= side_i.valid;
    end
  end

  assign valid_o     = valid_r;
  assign rel_angle_o = $signed(rel_r);
  assign zero_o      = zero_r;

endmodule

// ===== rtl/relative_heading_angle.sv =====
// An accepted start passes each stage named below before the out_valid strobe.
// Throughput: one beat every cycle; busy is never raised, as the fold stage,
// one cell per CORDIC micro-rotation and the output stage are all registered.
// Reset: synchronous, active low; it clears the valid bits down the chain only,
// so no result is strobed for beats that were in flight. The receiver cannot stall.
module relative_heading_angle import rha_pkg::*; #(
  parameter int ITERATIONS = ITERATIONS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_vec_x,
  input  logic signed [15:0] in_vec_y,
  input  logic signed [15:0] in_heading,
  output logic               out_valid,
  output logic signed [15:0] out_rel_angle,
  output logic               out_zero_vector
);

  localparam int LATENCY = ITERATIONS + 2;

  logic signed [XY_W-1:0]       x_c [ITERATIONS+1];
  logic signed [XY_W-1:0]       y_c [ITERATIONS+1];
  logic        [ANGLE_BITS-1:0] z_c [ITERATIONS+1];
  side_t                        side_c [ITERATIONS+1];

  assign busy = 1'b0;

  rha_prerot #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_prerot (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (start && !busy),
    .vec_x  (in_vec_x),
    .vec_y  (in_vec_y),
    .heading(in_heading),
    .x_o    (x_c[0]),
    .y_o    (y_c[0]),
    .z_o    (z_c[0]),
    .side_o (side_c[0])
  );

  generate
    for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
      rha_cell #(
        .STEP      (i),
        .ANGLE_BITS(ANGLE_BITS)
      ) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .x_i   (x_c[i]),
        .y_i   (y_c[i]),
        .z_i   (z_c[i]),
        .side_i(side_c[i]),
        .x_o   (x_c[i+1]),
        .y_o   (y_c[i+1]),
        .z_o   (z_c[i+1]),
        .side_o(side_c[i+1])
      );
    end
  endgenerate

  rha_post #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .z_i        (z_c[ITERATIONS]),
    .side_i     (side_c[ITERATIONS]),
    .valid_o    (out_valid),
    .rel_angle_o(out_rel_angle),
    .zero_o     (out_zero_vector)
  );

`ifndef NO_ASSERTIONS
  a_beat_emerges: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted beat did not produce a result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##LATENCY !out_valid)
    else $error("result strobed without an accepted beat");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_vec_x == 16'sd0 && in_vec_y == 16'sd0)
      |-> ##LATENCY (out_zero_vector && out_rel_angle == 16'sd0))
    else $error("zero vector not flagged with a zero angle");
`endif

endmodule
